// ===== rtl/core/pfc_pkg.sv =====
// ---------------------------------------------------------------------------
// pfc_pkg
// types, constants and helper functions for the playfair digraph cipher
// ---------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

   localparam int LetterW  = 5;
   localparam int SideLen  = 5;
   localparam int SquareW  = LetterW * SideLen * SideLen;
   localparam int RowPairW = 2 * LetterW * SideLen;
   localparam int CsrW     = RowPairW;
   localparam int CsrIdxW  = 3;

   typedef logic [LetterW-1:0] letter_type;
   typedef logic [2:0]         coord_type;
   typedef logic [3:0]         offset_type;
   typedef logic [1:0]         pair_addr_type;
   typedef logic [RowPairW-1:0] row_pair_type;
   typedef logic [SquareW-1:0] square_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_DECRYPT_MODE = 3'd0,
      CSR_ROWS_0_1     = 3'd1,
      CSR_ROWS_2_3     = 3'd2,
      CSR_ROW_4        = 3'd3,
      CSR_FILLER       = 3'd4
   } csr_index_type;

   localparam letter_type LETTER_I     = 5'd8;
   localparam letter_type LETTER_J     = 5'd9;
   localparam letter_type FILLER_RESET = 5'd23;
   localparam coord_type  COORD_LAST   = 3'd4;

   // one digraph waiting to be mapped, or an odd-length error
   typedef struct packed {
      letter_type a;
      letter_type b;
      logic       last;
      logic       err;
   } job_type;

   // located and rule-mapped cell positions
   typedef struct packed {
      coord_type row1;
      coord_type col1;
      coord_type row2;
      coord_type col2;
      logic      last;
      logic      err;
   } pos_type;

   function automatic letter_type norm_letter(input letter_type l);
      return (l == LETTER_J) ? LETTER_I : l;
   endfunction

   // one step round the square, forward or backward
   function automatic coord_type step_mod5(input coord_type x, input logic back);
      coord_type y;
      if (back) begin
         y = (x == 3'd0) ? COORD_LAST : x - 3'd1;
      end else begin
         y = (x == COORD_LAST) ? 3'd0 : x + 3'd1;
      end
      return y;
   endfunction

   // row and column of the lowest cell holding the letter, cell 0 if none
   function automatic logic [5:0] locate(input square_type sq, input letter_type l);
      coord_type row;
      coord_type col;
      row = 3'd0;
      col = 3'd0;
      for (int r = SideLen - 1; r >= 0; r--) begin
         for (int c = SideLen - 1; c >= 0; c--) begin
            if (sq[(r * SideLen + c) * LetterW +: LetterW] == l) begin
               row = coord_type'(r);
               col = coord_type'(c);
            end
         end
      end
      return {row, col};
   endfunction

   function automatic pair_addr_type pair_addr(input coord_type row);
      return row[2:1];
   endfunction

   function automatic offset_type pair_offset(input coord_type row, input coord_type col);
      return {1'b0, col} + (row[0] ? 4'd5 : 4'd0);
   endfunction

   function automatic letter_type pick_cell(input row_pair_type d, input offset_type off);
      logic [5:0] base;
      base = {off, 2'b00} + {2'b00, off};
      return d[base +: LetterW];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/playfair_digraph_cipher.sv =====
// ---------------------------------------------------------------------------
// playfair_digraph_cipher
// Letters come in on the req_ stream, one word each, a=0 to z=25, with
// req_tlast on the final letter of a message. Letters are paired into
// digraphs and mapped through the 5x5 key square set by the csr_ port;
// each pair gives two words on the rsp_ stream, rsp_tlast on the final one.
// In encrypt mode doubled letters get the filler inserted and an odd final
// letter is padded; in decrypt mode an odd final letter gives a single word
// with rsp_tuser set. The csr_ port is to be written by the user only while the
// block is idle; this is not enforced. One result word a cycle while rsp_tready
// is high, as the output register sends a digraph's two letters in turn; a
// letter is taken every cycle while the output keeps pace, but a doubled final
// pair fills both job slots and holds off the next letter. The key square is
// held in a three-entry memory of row pairs read at both cell addresses of a
// digraph. Reset clears the held letter and the pipeline and restores the
// register defaults: encrypt, all-zero square, filler x. When rsp_tready is
// low the output word holds and the pipeline fills, then req_tready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module playfair_digraph_cipher (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [7:0]                  req_tdata,   // letter_in, zeros
   input  wire logic                        req_tlast,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [7:0]                       rsp_tdata,   // letter_out, zeros
   output logic                             rsp_tlast,
   output logic                             rsp_tuser,   // odd_error
   input  wire logic                        csr_we,
   input  wire logic [pfc_pkg::CsrIdxW-1:0] csr_index,
   input  wire logic [pfc_pkg::CsrW-1:0]    csr_wdata
);
   import pfc_pkg::*;

   // configuration
   logic         mode_ff;
   letter_type   filler_ff;
   square_type   square_ff;
   row_pair_type sq_mem [0:2];
   logic [2:0]   sq_vld_ff;

   // held letter
   logic       held_valid_ff, held_valid_in;
   letter_type held_letter_ff, held_letter_in;

   // job slots
   logic    j1_valid_ff, j1_valid_in;
   job_type j1_ff, j1_in;
   logic    j2_valid_ff, j2_valid_in;
   job_type j2_ff, j2_in;

   // located positions
   logic    s2_valid_ff, s2_valid_in;
   pos_type s2_ff, s2_in;

   // output register
   logic         s3_valid_ff, s3_valid_in;
   logic         s3_phase_ff, s3_phase_in;
   logic         s3_last_ff, s3_last_in;
   logic         s3_err_ff, s3_err_in;
   offset_type   off0_ff, off0_in, off1_ff, off1_in;
   row_pair_type rd0_ff, rd1_ff;
   logic         rd0_ok_ff, rd1_ok_ff;

   logic       req_fire, rsp_fire, s3_done, s3_free, s2_adv, s2_free, j1_adv;
   letter_type in_letter, fill;
   logic       job0_valid, job1_valid;
   job_type    job0, job1;
   logic [5:0] loc1, loc2;
   coord_type  r1, c1, r2, c2;
   letter_type cur_letter;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         filler_ff <= FILLER_RESET;
         square_ff <= '0;
         sq_vld_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DECRYPT_MODE: mode_ff <= csr_wdata[0];
            CSR_ROWS_0_1: begin
               square_ff[RowPairW-1:0] <= csr_wdata;
               sq_vld_ff[0]            <= 1'b1;
            end
            CSR_ROWS_2_3: begin
               square_ff[2*RowPairW-1:RowPairW] <= csr_wdata;
               sq_vld_ff[1]                     <= 1'b1;
            end
            CSR_ROW_4: begin
               square_ff[SquareW-1:2*RowPairW] <= csr_wdata[SquareW-2*RowPairW-1:0];
               sq_vld_ff[2]                    <= 1'b1;
            end
            CSR_FILLER: filler_ff <= csr_wdata[LetterW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS_0_1: sq_mem[0] <= csr_wdata;
            CSR_ROWS_2_3: sq_mem[1] <= csr_wdata;
            CSR_ROW_4: sq_mem[2] <=
               {{(RowPairW-(SquareW-2*RowPairW)){1'b0}},
                csr_wdata[SquareW-2*RowPairW-1:0]};
            default: ;
         endcase
      end
   end

   // ---------------- handshakes ----------------
   assign rsp_fire   = rsp_tvalid & rsp_tready;
   assign s3_done    = rsp_fire & (s3_phase_ff | s3_err_ff);
   assign s3_free    = ~s3_valid_ff | s3_done;
   assign s2_adv     = s2_valid_ff & s3_free;
   assign s2_free    = ~s2_valid_ff | s2_adv;
   assign j1_adv     = j1_valid_ff & s2_free;
   assign req_tready = ~j2_valid_ff & (~j1_valid_ff | j1_adv);
   assign req_fire   = req_tvalid & req_tready;

   // ---------------- pairing ----------------
   assign in_letter = norm_letter(req_tdata[LetterW-1:0]);
   assign fill      = norm_letter(filler_ff);

   always_comb begin
      held_valid_in  = held_valid_ff;
      held_letter_in = held_letter_ff;
      job0_valid     = 1'b0;
      job1_valid     = 1'b0;
      job0           = '{a: in_letter, b: fill, last: 1'b1, err: 1'b0};
      job1           = '{a: in_letter, b: fill, last: 1'b1, err: 1'b0};
      if (req_fire) begin
         priority if (mode_ff) begin
            priority if (held_valid_ff) begin
               job0_valid     = 1'b1;
               job0           = '{a: held_letter_ff, b: in_letter, last: req_tlast,
                                  err: 1'b0};
               held_valid_in  = 1'b0;
               held_letter_in = '0;
            end else if (req_tlast) begin
               job0_valid = 1'b1;
               job0       = '{a: '0, b: '0, last: 1'b1, err: 1'b1};
            end else begin
               held_valid_in  = 1'b1;
               held_letter_in = in_letter;
            end
         end else if (~held_valid_ff) begin
            if (req_tlast) begin
               job0_valid = 1'b1;
            end else begin
               held_valid_in  = 1'b1;
               held_letter_in = in_letter;
            end
         end else if (held_letter_ff == in_letter && held_letter_ff != fill) begin
            job0_valid = 1'b1;
            job0       = '{a: held_letter_ff, b: fill, last: 1'b0, err: 1'b0};
            if (req_tlast) begin
               job1_valid     = 1'b1;
               held_valid_in  = 1'b0;
               held_letter_in = '0;
            end
         end else begin
            job0_valid     = 1'b1;
            job0           = '{a: held_letter_ff, b: in_letter, last: req_tlast, err: 1'b0};
            held_valid_in  = 1'b0;
            held_letter_in = '0;
         end
      end
   end

   // ---------------- job slots ----------------
   always_comb begin
      j1_valid_in = j1_valid_ff;
      j1_in       = j1_ff;
      j2_valid_in = j2_valid_ff;
      j2_in       = j2_ff;
      priority if (j2_valid_ff) begin
         if (j1_adv) begin
            j1_valid_in = 1'b1;
            j1_in       = j2_ff;
            j2_valid_in = 1'b0;
         end
      end else if (req_fire) begin
         j1_valid_in = job0_valid;
         j1_in       = job0;
         j2_valid_in = job1_valid;
         j2_in       = job1;
      end else if (j1_adv) begin
         j1_valid_in = 1'b0;
      end
   end

   // ---------------- locate and map ----------------
   always_comb begin
      loc1 = locate(square_ff, j1_ff.a);
      loc2 = locate(square_ff, j1_ff.b);
      r1   = loc1[5:3];
      c1   = loc1[2:0];
      r2   = loc2[5:3];
      c2   = loc2[2:0];
      priority if (r1 == r2) begin
         c1 = step_mod5(c1, mode_ff);
         c2 = step_mod5(c2, mode_ff);
      end else if (c1 == c2) begin
         r1 = step_mod5(r1, mode_ff);
         r2 = step_mod5(r2, mode_ff);
      end else begin
         c1 = loc2[2:0];
         c2 = loc1[2:0];
      end
      s2_in = '{row1: r1, col1: c1, row2: r2, col2: c2,
                last: j1_ff.last, err: j1_ff.err};
      s2_valid_in = j1_adv | (s2_valid_ff & ~s2_adv);
   end

   // ---------------- output register ----------------
   always_comb begin
      s3_valid_in = s3_valid_ff;
      s3_phase_in = s3_phase_ff;
      s3_last_in  = s3_last_ff;
      s3_err_in   = s3_err_ff;
      off0_in     = off0_ff;
      off1_in     = off1_ff;
      priority if (s2_adv) begin
         s3_valid_in = 1'b1;
         s3_phase_in = 1'b0;
         s3_last_in  = s2_ff.last;
         s3_err_in   = s2_ff.err;
         off0_in     = pair_offset(s2_ff.row1, s2_ff.col1);
         off1_in     = pair_offset(s2_ff.row2, s2_ff.col2);
      end else if (s3_done) begin
         s3_valid_in = 1'b0;
      end else if (rsp_fire) begin
         s3_phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rd0_ff    <= sq_mem[pair_addr(s2_ff.row1)];
         rd1_ff    <= sq_mem[pair_addr(s2_ff.row2)];
         rd0_ok_ff <= sq_vld_ff[pair_addr(s2_ff.row1)];
         rd1_ok_ff <= sq_vld_ff[pair_addr(s2_ff.row2)];
      end
   end

   always_comb begin
      priority if (s3_err_ff) begin
         cur_letter = '0;
      end else if (s3_phase_ff) begin
         cur_letter = rd1_ok_ff ? pick_cell(rd1_ff, off1_ff) : '0;
      end else begin
         cur_letter = rd0_ok_ff ? pick_cell(rd0_ff, off0_ff) : '0;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = {{(8-LetterW){1'b0}}, cur_letter};
   assign rsp_tlast  = s3_err_ff | (s3_phase_ff & s3_last_ff);
   assign rsp_tuser  = s3_err_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff  <= 1'b0;
         held_letter_ff <= '0;
         j1_valid_ff    <= 1'b0;
         j2_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         s3_phase_ff    <= 1'b0;
      end else begin
         held_valid_ff  <= held_valid_in;
         held_letter_ff <= held_letter_in;
         j1_valid_ff    <= j1_valid_in;
         j2_valid_ff    <= j2_valid_in;
         s2_valid_ff    <= s2_valid_in;
         s3_valid_ff    <= s3_valid_in;
         s3_phase_ff    <= s3_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      j1_ff      <= j1_in;
      j2_ff      <= j2_in;
      s3_last_ff <= s3_last_in;
      s3_err_ff  <= s3_err_in;
      off0_ff    <= off0_in;
      off1_ff    <= off1_in;
      if (j1_adv) begin
         s2_ff <= s2_in;
      end
   end

endmodule

`default_nettype wire
